@@ rtl/prefix_code_symbol_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the prefix code symbol decoder.
// They expect signals named clk and arst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_SYMBOL_DECODER_MACROS_SVH
`define PREFIX_CODE_SYMBOL_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prefix code symbol decoder: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prefix code symbol decoder: assertion failed");

`endif

@@ rtl/pcsd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsd_pkg
// Types and constants shared by the prefix code symbol decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsd_pkg;

	localparam int BYTE_BITS = 8;
	localparam int BITCNT_W  = 4;
	localparam int PIXCNT_W  = 25;
	localparam int PADDR_W   = 2;
	localparam int PDATA_W   = 32;

	localparam logic [PIXCNT_W-1:0] PIXCNT_RESET = 25'd65536;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic [PADDR_W-1:0] REG_PIXEL_COUNT = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_SCAN,
		ST_REC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic shift;
		logic scan;
		logic record;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bits_left;
		logic full;
		logic hit;
		logic scan_end;
		logic err_len;
		logic can_record;
		logic can_finish;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/pcsd_stream_if.sv @@
// ----------------------------------------------------------------------------
// pcsd_stream_if
// Input channel: code table loads and stream bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcsd_stream_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  symbol;
	logic [4:0]  code_length;
	logic [15:0] code_value;
	logic [7:0]  data_byte;
	logic [3:0]  valid_bits;
	logic        final_byte;

	modport source (
		output valid, func, symbol, code_length, code_value, data_byte, valid_bits,
		       final_byte,
		input  ready
	);
	modport sink (
		input  valid, func, symbol, code_length, code_value, data_byte, valid_bits,
		       final_byte,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/pcsd_result_if.sv @@
// ----------------------------------------------------------------------------
// pcsd_result_if
// Output channel: decoded pixels and error status.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       status;
	logic       image_done;
	logic       last;

	modport source (
		output valid, pixel, status, image_done, last,
		input  ready
	);
	modport sink (
		input  valid, pixel, status, image_done, last,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/pcsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcsd_ctrl
// Sequencer: steps through the bits of a byte and the table scan per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_ctrl
	import pcsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_func,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_func == FUNC_DATA) state_d = ST_BIT;
			end
			ST_BIT: begin
				state_d = (stat.bits_left && !stat.full) ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (stat.hit) begin
					state_d = ST_REC;
				end else if (stat.scan_end) begin
					state_d = stat.err_len ? ST_REC : ST_BIT;
				end
			end
			ST_REC: begin
				if (stat.can_record) state_d = ST_BIT;
			end
			ST_FINISH: begin
				if (stat.can_finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid && (in_func == FUNC_LOAD);
		cmd.start  = (state_q == ST_IDLE) && in_valid && (in_func == FUNC_DATA);
		cmd.shift  = (state_q == ST_BIT) && stat.bits_left && !stat.full;
		cmd.scan   = (state_q == ST_SCAN) && !stat.hit && !stat.scan_end;
		cmd.record = (state_q == ST_REC) && stat.can_record;
		cmd.finish = (state_q == ST_FINISH) && stat.can_finish;
	end

endmodule

`default_nettype wire

@@ rtl/pcsd_datapath.sv @@
// ----------------------------------------------------------------------------
// pcsd_datapath
// Code table memory, bit accumulator, table scan compare and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_datapath
	import pcsd_pkg::*;
#(
	parameter int MAX_CODE_LEN = 16,
	parameter int NUM_SYMBOLS  = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [7:0]          symbol,
	input  logic [4:0]          code_length,
	input  logic [15:0]         code_value,
	input  logic [7:0]          data_byte,
	input  logic [3:0]          valid_bits,
	input  logic                final_byte,
	input  logic [PIXCNT_W-1:0] pixel_count,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          out_pixel,
	output logic                out_status,
	output logic                out_image_done,
	output logic                out_last
);

	localparam int SW = $clog2(NUM_SYMBOLS);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int CW = MAX_CODE_LEN;
	localparam logic [SW-1:0] LAST_SYM = SW'(NUM_SYMBOLS - 1);

	logic [LW+CW-1:0]      mem_q [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] valid_q;

	logic                  sym_ok;
	logic [LW-1:0]         len_w;
	logic [CW-1:0]         code_w;

	logic [SW-1:0]         scan_idx_q;
	logic [LW+CW-1:0]      rd_s1;
	logic                  vld_s1;
	logic                  cmp_v_s1;
	logic [SW-1:0]         idx_s1;
	logic                  match;

	logic [CW-1:0]         pend_bits_q;
	logic [LW-1:0]         pend_len_q;
	logic [7:0]            byte_q;
	logic [BITCNT_W-1:0]   nbits_q;
	logic [BITCNT_W-1:0]   bitcnt_q;
	logic                  fin_q;
	logic [PIXCNT_W-1:0]   pix_done_q;
	logic [PIXCNT_W-1:0]   pix_next;

	logic                  hold_v_q;
	logic [7:0]            hold_pix_q;
	logic                  hold_st_q;
	logic                  hold_done_q;
	logic                  out_free;

	assign sym_ok = (9'(symbol) < 9'(NUM_SYMBOLS));
	assign len_w  = ({1'b0, code_length} > 6'(MAX_CODE_LEN)) ? '0 : LW'(code_length);
	assign code_w = CW'(code_value) & ((CW'(1) << len_w) - CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load && sym_ok) begin
			mem_q[symbol[SW-1:0]] <= {len_w, code_w};
		end
		if (cmd.scan) begin
			rd_s1  <= mem_q[scan_idx_q];
			idx_s1 <= scan_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			vld_s1     <= 1'b0;
			cmp_v_s1   <= 1'b0;
			scan_idx_q <= '0;
		end else begin
			if (cmd.load && sym_ok) valid_q[symbol[SW-1:0]] <= 1'b1;
			if (cmd.shift) begin
				scan_idx_q <= '0;
				cmp_v_s1   <= 1'b0;
			end else if (cmd.scan) begin
				vld_s1   <= valid_q[scan_idx_q];
				cmp_v_s1 <= 1'b1;
				if (scan_idx_q != LAST_SYM) scan_idx_q <= scan_idx_q + SW'(1);
			end
		end
	end

	assign match = cmp_v_s1 && vld_s1 && (rd_s1[LW+CW-1:CW] != '0)
		&& (rd_s1[LW+CW-1:CW] == pend_len_q) && (rd_s1[CW-1:0] == pend_bits_q);
	assign pix_next = pix_done_q + PIXCNT_W'(1);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		stat            = '0;
		stat.bits_left  = (bitcnt_q != nbits_q);
		stat.full       = (pix_done_q >= pixel_count);
		stat.hit        = match;
		stat.scan_end   = cmp_v_s1 && !match && (idx_s1 == LAST_SYM);
		stat.err_len    = (pend_len_q >= LW'(MAX_CODE_LEN));
		stat.can_record = !hold_v_q || out_free;
		stat.can_finish = !hold_v_q || out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_len_q  <= '0;
			pix_done_q  <= '0;
			bitcnt_q    <= '0;
			nbits_q     <= '0;
			fin_q       <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.start) begin
				fin_q    <= final_byte;
				bitcnt_q <= '0;
				if (!final_byte) begin
					nbits_q <= BITCNT_W'(BYTE_BITS);
				end else begin
					nbits_q <= (valid_bits > BITCNT_W'(BYTE_BITS)) ? BITCNT_W'(BYTE_BITS)
						: valid_bits;
				end
			end
			if (cmd.shift) begin
				pend_bits_q <= CW'({pend_bits_q, byte_q[7]});
				pend_len_q  <= pend_len_q + LW'(1);
				bitcnt_q    <= bitcnt_q + BITCNT_W'(1);
			end
			if (cmd.record) begin
				pend_bits_q <= '0;
				pend_len_q  <= '0;
				hold_v_q    <= 1'b1;
				if (match) pix_done_q <= pix_next;
			end
			if (cmd.finish) begin
				hold_v_q <= 1'b0;
				if (fin_q) begin
					pend_bits_q <= '0;
					pend_len_q  <= '0;
					pix_done_q  <= '0;
				end
			end
			if ((cmd.record || cmd.finish) && hold_v_q) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) byte_q <= data_byte;
		if (cmd.shift) byte_q <= {byte_q[6:0], 1'b0};
		if (cmd.record) begin
			hold_pix_q  <= match ? 8'(idx_s1) : 8'd0;
			hold_st_q   <= match ? STATUS_OK : STATUS_ERR;
			hold_done_q <= match && (pix_next == pixel_count);
		end
		if ((cmd.record || cmd.finish) && hold_v_q) begin
			out_pixel      <= hold_pix_q;
			out_status     <= hold_st_q;
			out_image_done <= hold_done_q;
			out_last       <= cmd.finish;
		end
	end

endmodule

`default_nettype wire

@@ rtl/prefix_code_symbol_decoder.sv @@
// ----------------------------------------------------------------------------
// prefix_code_symbol_decoder
// Table-match prefix code decoder: loads a code table and turns stream bytes
// into pixel values, with an APB register for the pixel count.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// stream    in   table load or stream byte (valid/ready)
// result    out  pixel, status, image_done, last (valid/ready)
// apb       in   pixel_count register at byte address 0
//
// A table load is written while idle, and the decoder stays ready after it.
// A stream byte is decoded bit by bit: each bit is shifted in, then the code
// table is scanned at one table entry per cycle through its single read port.
// Reset clears the table (all codes unused) and the decoder state at once.
// A result waits in a holding register and then in the output register; the
// decoder stalls only when both are full and the output is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_symbol_decoder
	import pcsd_pkg::*;
#(
	parameter int MAX_CODE_LEN = 16,
	parameter int NUM_SYMBOLS  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	pcsd_stream_if.sink        stream,
	pcsd_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [PIXCNT_W-1:0] pixel_count_q;
	cmd_t                cmd;
	stat_t               stat;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_PIXEL_COUNT)
		? {{(PDATA_W - PIXCNT_W){1'b0}}, pixel_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIXCNT_RESET;
		end else if (psel && penable && pwrite && paddr == REG_PIXEL_COUNT) begin
			pixel_count_q <= pwdata[PIXCNT_W-1:0];
		end
	end

	pcsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_func  (stream.func),
		.in_ready (stream.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcsd_datapath #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.NUM_SYMBOLS  (NUM_SYMBOLS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.symbol         (stream.symbol),
		.code_length    (stream.code_length),
		.code_value     (stream.code_value),
		.data_byte      (stream.data_byte),
		.valid_bits     (stream.valid_bits),
		.final_byte     (stream.final_byte),
		.pixel_count    (pixel_count_q),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_pixel      (result.pixel),
		.out_status     (result.status),
		.out_image_done (result.image_done),
		.out_last       (result.last)
	);

endmodule

`default_nettype wire

@@ rtl/pcsd_checker.sv @@
// ----------------------------------------------------------------------------
// pcsd_checker
// Port-level checks on the prefix code symbol decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prefix_code_symbol_decoder_macros.svh"

module pcsd_checker
	import pcsd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_pixel,
	input logic       out_status,
	input logic       out_image_done,
	input logic       out_last
);

	`PCSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PCSD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pixel) && $stable(out_status) && $stable(out_image_done) && $stable(out_last))
	`PCSD_ASSERT_SAME(a_err_clean, out_valid && out_status == STATUS_ERR, out_pixel == 8'd0 && !out_image_done)
	`PCSD_ASSERT_NEXT(a_load_one_cycle, in_valid && in_ready && in_func == FUNC_LOAD, in_ready)

endmodule

bind prefix_code_symbol_decoder pcsd_checker u_pcsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (stream.valid),
	.in_ready       (stream.ready),
	.in_func        (stream.func),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_pixel      (result.pixel),
	.out_status     (result.status),
	.out_image_done (result.image_done),
	.out_last       (result.last)
);

`default_nettype wire
